FILE: rtl/core/sasf_pkg.sv
// Shared types and constants of the Sobel-weighted 5x5 smoothing filter.
// No dependencies; used by every module of the block.
package sasf_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int ROW_SLOTS     = 8;
    localparam int SLOT_W        = $clog2(ROW_SLOTS);
    localparam int ADDR_W        = SLOT_W + COL_W;
    localparam int MEM_DEPTH     = ROW_SLOTS * MAX_WIDTH;
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 12;
    localparam int CENTRE_WEIGHT = 30;
    localparam int PADDR_W       = 3;

    localparam logic [PADDR_W-1:0] REG_WIDTH  = 3'h0;
    localparam logic [PADDR_W-1:0] REG_HEIGHT = 3'h4;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       is_flush;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic take;
        logic start;
        logic read;
        logic square;
        logic root_init;
        logic root;
        logic weight;
        logic div;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ready;
        logic read_done;
        logic root_done;
        logic div_done;
    } t_stat;

endpackage

FILE: rtl/core/sobel_adaptive_smoothing_filter.sv
// A pixel that completes no window is only stored; one that does is filtered
// through 25 line-memory reads, 11 root steps and 8 divide steps.
// Throughput: one transaction at a time, bounded by the single memory read port
// and the bit-serial root and divider. Reset (i_rst_n low, synchronous) clears
// counters and handshakes and restores 640x480; line memory is not cleared.
// Depends on sasf_pkg, sasf_ctrl, sasf_dp.
module sobel_adaptive_smoothing_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sasf_pkg::t_in_item            i_in_item,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sasf_pkg::t_out_item           o_out_item,
    // APB-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sasf_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [sasf_pkg::WIDTH_W-1:0]  r_width;
    logic [sasf_pkg::HEIGHT_W-1:0] r_height;
    logic                          cfg_wr;
    logic                          restart;
    sasf_pkg::t_cmd                cmd;
    sasf_pkg::t_stat               stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Address bit 2 picks the register; a write to either restarts the frame
    // and drops any partial progress through the raster.
    assign restart = cfg_wr && ((paddr[2] == sasf_pkg::REG_WIDTH[2])
                             || (paddr[2] == sasf_pkg::REG_HEIGHT[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sasf_pkg::WIDTH_RST;
            r_height <= sasf_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == sasf_pkg::REG_HEIGHT[2]) begin
                r_height <= pwdata[sasf_pkg::HEIGHT_W-1:0];
            end else begin
                r_width <= pwdata[sasf_pkg::WIDTH_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == sasf_pkg::REG_HEIGHT[2]) begin
            prdata = {{(32-sasf_pkg::HEIGHT_W){1'b0}}, r_height};
        end else begin
            prdata = {{(32-sasf_pkg::WIDTH_W){1'b0}}, r_width};
        end
    end

    // sequencer: owns the handshakes, steps the datapath through each pixel
    sasf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // datapath: line memory, window sums, root, divider, output register
    sasf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

FILE: rtl/core/sasf_ctrl.sv
// Sequencer of the smoothing filter: handshakes and per-pixel phases.
// Depends on sasf_pkg (t_cmd, t_stat).
module sasf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sasf_pkg::t_cmd o_cmd,
    input  sasf_pkg::t_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_READ, S_SQUARE, S_ROOT_INIT, S_ROOT, S_WEIGHT, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.take      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.start     = (r_state == S_CHECK) && i_stat.ready;
        o_cmd.read      = (r_state == S_READ);
        o_cmd.square    = (r_state == S_SQUARE);
        o_cmd.root_init = (r_state == S_ROOT_INIT);
        o_cmd.root      = (r_state == S_ROOT) && !i_stat.root_done;
        o_cmd.weight    = (r_state == S_WEIGHT);
        o_cmd.div       = (r_state == S_DIV) && !i_stat.div_done;
        o_cmd.emit      = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_CHECK;
                        r_in_stall <= 1'b1;
                    end
                end
                S_CHECK: begin
                    if (i_stat.ready) begin
                        r_state <= S_READ;
                    end else begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                S_READ: begin
                    if (i_stat.read_done) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE:    r_state <= S_ROOT_INIT;
                S_ROOT_INIT: r_state <= S_ROOT;
                S_ROOT: begin
                    if (i_stat.root_done) begin
                        r_state <= S_WEIGHT;
                    end
                end
                S_WEIGHT: r_state <= S_DIV;
                S_DIV: begin
                    if (i_stat.div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        r_in_stall  <= 1'b0;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_stall <= 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/sasf_dp.sv
// Datapath of the smoothing filter: line memory, raster counters, window
// accumulation, bit-serial square root and divider. Depends on sasf_pkg.
module sasf_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_restart,
    input  logic [sasf_pkg::WIDTH_W-1:0]      i_width,
    input  logic [sasf_pkg::HEIGHT_W-1:0]     i_height,
    input  sasf_pkg::t_cmd                    i_cmd,
    output sasf_pkg::t_stat                   o_stat,
    input  sasf_pkg::t_in_item                i_in_item,
    output sasf_pkg::t_out_item               o_out_item
);

    localparam int WW = sasf_pkg::WIDTH_W;
    localparam int HW = sasf_pkg::HEIGHT_W;

    logic [23:0] r_mem [sasf_pkg::MEM_DEPTH];
    logic [23:0] r_rdata;

    logic [WW-1:0] r_in_col, r_out_col, w_eff;
    logic [HW-1:0] r_in_row, r_out_row, h_eff;

    logic [2:0] r_dx, r_dy, r_ddx, r_ddy;
    logic       r_issue, r_dvld;

    logic [2:0][12:0] r_sum;
    logic [2:0][7:0]  r_cen;
    logic signed [11:0] r_gx, r_gy;
    logic [20:0] r_sqx, r_sqy, r_v, r_res, r_bit;

    logic [2:0][17:0] r_rem;
    logic [2:0][7:0]  r_quo;
    logic [17:0]      r_dsh;
    logic [3:0]       r_div_left;
    sasf_pkg::t_out_item r_out;

    logic wr_en, rd_en, frame_last;
    logic [sasf_pkg::ADDR_W-1:0] waddr, raddr;
    logic [12:0] x_u;
    logic [13:0] y_u;
    logic [WW-1:0] rd_col, nc;
    logic [HW-1:0] rd_row, nr;
    logic [7:0] red;
    logic signed [11:0] red_s, mag_x, mag_y, gx_term, gy_term;
    logic in3;
    logic signed [23:0] px2, py2;
    logic [21:0] trial;
    logic [17:0] q_full;
    logic [4:0]  wt;
    logic [2:0][12:0] nb;

    // effective geometry
    always_comb begin
        if (i_width == '0) begin
            w_eff = WW'(1);
        end else if (i_width > WW'(sasf_pkg::MAX_WIDTH)) begin
            w_eff = WW'(sasf_pkg::MAX_WIDTH);
        end else begin
            w_eff = i_width;
        end
        h_eff = (i_height == '0) ? HW'(1) : i_height;
    end

    assign wr_en = i_cmd.take && !i_in_item.is_flush && (r_in_row < h_eff);
    assign waddr = {r_in_row[sasf_pkg::SLOT_W-1:0], r_in_col[sasf_pkg::COL_W-1:0]};
    assign frame_last = (r_out_row == h_eff - HW'(1)) && (r_out_col == w_eff - WW'(1));

    // window of the output pixel needs (min(r+2,H-1), min(c+2,W-1)) stored
    always_comb begin
        if (({1'b0, r_out_row} + 13'd2) < {1'b0, h_eff}) begin
            nr = r_out_row + HW'(2);
        end else begin
            nr = h_eff - HW'(1);
        end
        if (({1'b0, r_out_col} + 12'd2) < {1'b0, w_eff}) begin
            nc = r_out_col + WW'(2);
        end else begin
            nc = w_eff - WW'(1);
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.ready     = (nr < r_in_row) || ((nr == r_in_row) && (nc < r_in_col));
        o_stat.read_done = !r_issue && !r_dvld;
        o_stat.root_done = (r_bit == '0);
        o_stat.div_done  = (r_div_left == '0);
    end

    // window tap address with edge clamping
    always_comb begin
        x_u = {2'b00, r_out_col} + {10'b0, r_dx};
        y_u = {2'b00, r_out_row} + {11'b0, r_dy};
        if (x_u < 13'd2) begin
            rd_col = '0;
        end else if ((x_u - 13'd2) >= {2'b00, w_eff}) begin
            rd_col = w_eff - WW'(1);
        end else begin
            rd_col = WW'(x_u - 13'd2);
        end
        if (y_u < 14'd2) begin
            rd_row = '0;
        end else if ((y_u - 14'd2) >= {2'b00, h_eff}) begin
            rd_row = h_eff - HW'(1);
        end else begin
            rd_row = HW'(y_u - 14'd2);
        end
        raddr = {rd_row[sasf_pkg::SLOT_W-1:0], rd_col[sasf_pkg::COL_W-1:0]};
    end

    assign rd_en = i_cmd.read && r_issue;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr] <= {i_in_item.in_red, i_in_item.in_green, i_in_item.in_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            if (wr_en) begin
                if ((r_in_col + WW'(1)) >= w_eff) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + HW'(1);
                end else begin
                    r_in_col <= r_in_col + WW'(1);
                end
            end
            if (i_cmd.emit) begin
                if (frame_last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if ((r_out_col + WW'(1)) >= w_eff) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + HW'(1);
                end else begin
                    r_out_col <= r_out_col + WW'(1);
                end
            end
        end
    end

    // Sobel terms of red for the tap whose data is in r_rdata
    always_comb begin
        red     = r_rdata[23:16];
        red_s   = {4'b0, red};
        in3     = (r_ddx >= 3'd1) && (r_ddx <= 3'd3) && (r_ddy >= 3'd1) && (r_ddy <= 3'd3);
        mag_x   = (r_ddy == 3'd2) ? (red_s <<< 1) : red_s;
        mag_y   = (r_ddx == 3'd2) ? (red_s <<< 1) : red_s;
        gx_term = '0;
        gy_term = '0;
        if (in3) begin
            if (r_ddx == 3'd1) begin
                gx_term = mag_x;
            end else if (r_ddx == 3'd3) begin
                gx_term = -mag_x;
            end
            if (r_ddy == 3'd1) begin
                gy_term = mag_y;
            end else if (r_ddy == 3'd3) begin
                gy_term = -mag_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_dvld  <= 1'b0;
        end else if (i_cmd.start) begin
            r_issue <= 1'b1;
            r_dvld  <= 1'b0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_sum   <= '0;
            r_gx    <= '0;
            r_gy    <= '0;
        end else if (i_cmd.read) begin
            r_dvld <= r_issue;
            if (r_issue) begin
                r_ddx <= r_dx;
                r_ddy <= r_dy;
                if (r_dx == 3'd4) begin
                    r_dx <= '0;
                    if (r_dy == 3'd4) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_dy <= r_dy + 3'd1;
                    end
                end else begin
                    r_dx <= r_dx + 3'd1;
                end
            end
            if (r_dvld) begin
                for (int ch = 0; ch < 3; ch++) begin
                    r_sum[ch] <= r_sum[ch] + {5'b0, r_rdata[23-8*ch -: 8]};
                    if ((r_ddx == 3'd2) && (r_ddy == 3'd2)) begin
                        r_cen[ch] <= r_rdata[23-8*ch -: 8];
                    end
                end
                r_gx <= r_gx + gx_term;
                r_gy <= r_gy + gy_term;
            end
        end
    end

    // gradient magnitude and integer square root, one result bit a cycle
    assign px2   = r_gx * r_gx;
    assign py2   = r_gy * r_gy;
    assign trial = {1'b0, r_res} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_cmd.square) begin
            r_sqx <= px2[20:0];
            r_sqy <= py2[20:0];
        end else if (i_cmd.root_init) begin
            r_v   <= r_sqx + r_sqy;
            r_res <= '0;
            r_bit <= 21'(1) << 20;
        end else if (i_cmd.root) begin
            if ({1'b0, r_v} >= trial) begin
                r_v   <= r_v - trial[20:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // weight and numerators, then restoring division for three lanes
    always_comb begin
        q_full = 18'(r_res >> 3);
        wt = (q_full >= 18'(sasf_pkg::CENTRE_WEIGHT)) ? 5'd0
           : 5'(18'(sasf_pkg::CENTRE_WEIGHT) - q_full);
        for (int ch = 0; ch < 3; ch++) begin
            nb[ch] = r_sum[ch] - {5'b0, r_cen[ch]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_left <= '0;
        end else if (i_cmd.weight) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_rem[ch] <= 18'(r_cen[ch]) * 18'(sasf_pkg::CENTRE_WEIGHT)
                           + 18'(wt) * 18'(nb[ch]);
                r_quo[ch] <= '0;
            end
            r_dsh      <= 18'(18'(wt) * 18'd24 + 18'(sasf_pkg::CENTRE_WEIGHT)) << 7;
            r_div_left <= 4'd8;
        end else if (i_cmd.div) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (r_rem[ch] >= r_dsh) begin
                    r_rem[ch] <= r_rem[ch] - r_dsh;
                    r_quo[ch] <= {r_quo[ch][6:0], 1'b1};
                end else begin
                    r_quo[ch] <= {r_quo[ch][6:0], 1'b0};
                end
            end
            r_dsh      <= r_dsh >> 1;
            r_div_left <= r_div_left - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_red   <= r_quo[0];
            r_out.out_green <= r_quo[1];
            r_out.out_blue  <= r_quo[2];
            r_out.frame_end <= frame_last;
        end
    end

    assign o_out_item = r_out;

endmodule

FILE: rtl/core/sasf_checker.sv
// Port-level checks of the smoothing filter, bound to the top level.
// Depends on sasf_pkg and sobel_adaptive_smoothing_filter.
module sasf_port_checks (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input sasf_pkg::t_out_item           o_out_item
);

    // held result stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    // one transaction at a time: input stalls right after acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second transaction accepted back to back");

    // a new result only appears at the end of a transaction's work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a transaction in flight");

    // reset leaves both channels idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_in_stall && !o_out_valid))
        else $error("channels busy after reset");

endmodule

bind sobel_adaptive_smoothing_filter sasf_port_checks u_sasf_port_checks (.*);
